### rtl/isqr_pkg.sv
// ----------------------------------------------------------------------------
// Integer square root package
// Shared types for the controller and datapath of the square root block.
// ----------------------------------------------------------------------------
package isqr_pkg;

  // Controller state, one-hot encoded.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // Capture a new radicand and clear the partial root.
    logic step;  // Decide one root bit.
  } dp_cmd_t;

endpackage

### rtl/isqr_dp.sv
// ----------------------------------------------------------------------------
// Integer square root datapath
// Remainder, partial root and power-of-four registers with one trial
// subtraction per step.
// ----------------------------------------------------------------------------
module isqr_dp #(
  parameter int WIDTH = 64
) (
  input  logic               clk_i,
  input  isqr_pkg::dp_cmd_t  cmd_i,
  input  logic [63:0]        radicand_i,
  output logic [31:0]        root_o,
  output logic [32:0]        remainder_o,
  output logic               exact_o
);
  import isqr_pkg::*;

  localparam int Half = (WIDTH + 1) / 2;
  localparam int AccW = 2 * Half;
  localparam int CmpW = AccW + 1;

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [AccW-1:0]  bit_q, bit_d;
  logic [CmpW-1:0]  trial;
  logic [CmpW-1:0]  rem_ext;
  logic             fits;

  // Trial value is the partial root plus the current power of four.
  assign trial   = {1'b0, acc_q} + {1'b0, bit_q};
  assign rem_ext = CmpW'(rem_q);
  assign fits    = (rem_ext >= trial);

  // Next-state logic for the working registers.
  always_comb begin
    rem_d = rem_q;
    acc_d = acc_q;
    bit_d = bit_q;
    if (cmd_i.load) begin
      rem_d = radicand_i[WIDTH-1:0];
      acc_d = '0;
      bit_d = AccW'(1) << (AccW - 2);
    end else if (cmd_i.step) begin
      bit_d = bit_q >> 2;
      if (fits) begin
        rem_d = rem_q - trial[WIDTH-1:0];
        acc_d = (acc_q >> 1) + bit_q;
      end else begin
        acc_d = acc_q >> 1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    bit_q <= bit_d;
  end

  // Results are read straight from the working registers.
  assign root_o      = 32'(acc_q);
  assign remainder_o = 33'(rem_q);
  assign exact_o     = (rem_q == '0);

endmodule

### rtl/isqr_ctrl.sv
// ----------------------------------------------------------------------------
// Integer square root controller
// Sequences load, the root-bit iterations and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module isqr_ctrl #(
  parameter int WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               valid_o,
  output isqr_pkg::dp_cmd_t  cmd_o
);
  import isqr_pkg::*;

  localparam int Half = (WIDTH + 1) / 2;
  localparam int CntW = (Half > 1) ? $clog2(Half) : 1;
  localparam logic [CntW-1:0] CntInit = CntW'(Half - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign accept = start && !busy;

  // State and iteration counter transitions.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          cnt_d   = CntInit;
        end
      end
      S_RUN: begin
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Outputs and datapath commands.
  assign busy       = (state_q != S_IDLE);
  assign valid_o    = (state_q == S_DONE);
  assign cmd_o.load = accept;
  assign cmd_o.step = (state_q == S_RUN);

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN) && (cnt_q == CntInit))
    else $error("accepted word did not start the iterations");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && (cnt_q == '0) |=> valid_o)
    else $error("result strobe missing after the last iteration");

  a_valid_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe lasted more than one cycle");
`endif

endmodule

### rtl/integer_square_root_rem_top.sv
// One root bit is decided per cycle by a single shared add-and-compare stage.
// A new word is taken only when idle; busy is high until the result cycle
// ends. The receiver cannot stall, so the strobe lasts one cycle.
// Reset (rst_ni low, asynchronous) returns the controller to idle.
// ----------------------------------------------------------------------------
// Integer square root with remainder
// Digit-by-digit shift-and-subtract square root of an unsigned radicand,
// returning the floor root, the remainder and a perfect-square flag.
// ----------------------------------------------------------------------------
module integer_square_root_rem_top #(
  parameter int WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] radicand_i,
  output logic        valid_o,
  output logic [31:0] root_o,
  output logic [32:0] remainder_o,
  output logic        exact_o
);
  import isqr_pkg::*;

  dp_cmd_t cmd;

  // Controller: sequencing and handshake.
  isqr_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  // Datapath: remainder and root registers.
  isqr_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .radicand_i  (radicand_i),
    .root_o      (root_o),
    .remainder_o (remainder_o),
    .exact_o     (exact_o)
  );

endmodule

### sim/isqrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root result checker
// Watches the command and result ports of the square root block. It predicts
// the root, remainder and perfect-square flag of every accepted word and
// compares each result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module isqrt_checker #(
  parameter int WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [63:0] radicand_i,
  input  logic        valid_i,
  input  logic [31:0] root_i,
  input  logic [32:0] remainder_i,
  input  logic        exact_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    logic [31:0] root;
    logic [32:0] remainder;
    logic        exact;
  } sqrt_result_t;

  sqrt_result_t expected_roots_q[$];

  // Floor square root found one root bit at a time, from the top down: a bit
  // is kept when the square of the candidate root still fits in the radicand.
  function automatic sqrt_result_t isqrt_predict(input logic [63:0] value);
    logic [63:0]  operand;
    logic [63:0]  candidate;
    logic [63:0]  partial_root;
    logic [63:0]  leftover;
    int           root_bits;
    sqrt_result_t prediction;
    operand = (WIDTH >= 64) ? value : (value & ((64'd1 << WIDTH) - 64'd1));
    root_bits = (WIDTH + 1) / 2;
    if (root_bits > 32) begin
      root_bits = 32;
    end
    partial_root = '0;
    for (int b = root_bits - 1; b >= 0; b--) begin
      candidate = partial_root | (64'd1 << b);
      if (candidate * candidate <= operand) begin
        partial_root = candidate;
      end
    end
    leftover = operand - partial_root * partial_root;
    prediction.root      = partial_root[31:0];
    prediction.remainder = leftover[32:0];
    prediction.exact     = (leftover == 64'd0);
    return prediction;
  endfunction

  // Record each accepted word and check each result word as it strobes by.
  always @(posedge clk_i) begin
    sqrt_result_t oldest;
    if (rst_ni) begin
      if (valid_i) begin
        if (expected_roots_q.size() == 0) begin
          $error("Result word with no outstanding radicand: root %0d remainder %0d",
                 root_i, remainder_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          oldest = expected_roots_q.pop_front();
          if (root_i !== oldest.root) begin
            $error("root: expected %0d, actual %0d", oldest.root, root_i);
          end
          if (remainder_i !== oldest.remainder) begin
            $error("remainder: expected %0d, actual %0d", oldest.remainder, remainder_i);
          end
          if (exact_i !== oldest.exact) begin
            $error("exact: expected %0b, actual %0b", oldest.exact, exact_i);
          end
          if (root_i !== oldest.root || remainder_i !== oldest.remainder ||
              exact_i !== oldest.exact) begin
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_roots_q.push_back(isqrt_predict(radicand_i));
      end
      pending_count_o <= expected_roots_q.size();
    end
  end

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

endmodule

### sim/tb_integer_square_root_rem_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root block testbench
// Drives radicands into the square root block in random bursts, beginning with
// directed corner values, and lets a checker beside the block predict and
// compare every result word. Ends with a pass or fail verdict.
// ----------------------------------------------------------------------------
module tb_integer_square_root_rem_top;

  localparam int WIDTH          = 64;
  localparam int RANDOM_WORDS   = 1600;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] radicand_i;
  logic        valid_o;
  logic [31:0] root_o;
  logic [32:0] remainder_o;
  logic        exact_o;
  int          mismatch_count;
  int          pending_count;
  int          idle_cycles;

  integer_square_root_rem_top #(
    .WIDTH(WIDTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .radicand_i  (radicand_i),
    .valid_o     (valid_o),
    .root_o      (root_o),
    .remainder_o (remainder_o),
    .exact_o     (exact_o)
  );

  isqrt_checker #(
    .WIDTH(WIDTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .radicand_i       (radicand_i),
    .valid_i          (valid_o),
    .root_i           (root_o),
    .remainder_i      (remainder_o),
    .exact_i          (exact_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The watchdog ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || valid_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] random_word64();
    return {$urandom(), $urandom()};
  endfunction

  // Random radicands, weighted toward the places where the root is decided
  // by a narrow margin: just around perfect squares and on short values.
  function automatic logic [63:0] pick_radicand();
    logic [63:0] base_root;
    logic [63:0] square;
    logic [63:0] value;
    base_root = {32'd0, $urandom()};
    square    = base_root * base_root;
    case ($urandom_range(0, 3))
      0: begin
        value = random_word64();
      end
      1: begin
        case ($urandom_range(0, 3))
          0: value = square;
          1: value = (square == 64'd0) ? 64'd0 : square - 64'd1;
          2: value = square + 64'd1;
          default: value = square + 2 * base_root;
        endcase
      end
      2: begin
        value = random_word64() >> $urandom_range(0, 63);
      end
      default: begin
        value = 64'($urandom_range(0, 1000));
      end
    endcase
    return value;
  endfunction

  // Present one word and hold start until the block takes it. Returns at the
  // falling edge after the accepting edge, with start still high.
  task automatic send_radicand(input logic [63:0] value);
    start      <= 1'b1;
    radicand_i <= value;
    do begin
      @(posedge clk_i);
    end while (busy);
    @(negedge clk_i);
  endtask

  // Lower start for a random stretch, with noise on the radicand bus.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start      <= 1'b0;
      radicand_i <= random_word64();
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Stimulus: reset, directed corners, then random bursts, then drain.
  initial begin
    logic [63:0] corner_values[$];
    int          burst_left;
    int          sent;
    start       = 1'b0;
    radicand_i  = '0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    corner_values = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9, 64'd15, 64'd16,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
      64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
      64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
      64'h3FFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0000,
      64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555
    };
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed corners go back to back.
    foreach (corner_values[k]) begin
      send_radicand(corner_values[k]);
    end
    idle_gap($urandom_range(1, 10));

    // Random bursts; about a third of them follow on with no gap at all.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst_left = $urandom_range(1, 12);
      while (burst_left > 0 && sent < RANDOM_WORDS) begin
        send_radicand(pick_radicand());
        burst_left--;
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        idle_gap($urandom_range(1, 45));
      end
    end
    idle_gap(1);

    // Drain outstanding results, then give the block a little extra time.
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
